/* sv/mtg_pkg.sv */
// Package for the MT19937 generator: sizes, constants, action codes,
// the seeder control struct and the twist and tempering functions.
// Depends on nothing; every other file imports it.
package mtg_pkg;

    localparam int STATE_WORDS  = 624;
    localparam int SHIFT_OFFSET = 397;
    localparam int KEY_MAX      = 16;
    localparam int WORD_W       = 32;
    localparam int POS_W        = 10;
    localparam int KEY_IDX_W    = 4;
    localparam int KEY_CNT_W    = 5;

    typedef logic [WORD_W-1:0]    word_t;
    typedef logic [POS_W-1:0]     pos_t;
    typedef logic [KEY_IDX_W-1:0] key_idx_t;
    typedef logic [KEY_CNT_W-1:0] key_cnt_t;

    localparam word_t INIT_MULT   = 32'd1812433253;
    localparam word_t ARRAY_SEED  = 32'd19650218;
    localparam word_t MIX1_MULT   = 32'd1664525;
    localparam word_t MIX2_MULT   = 32'd1566083941;
    localparam word_t MATRIX_A    = 32'h9908B0DF;
    localparam word_t TEMPER_B    = 32'h9D2C5680;
    localparam word_t TEMPER_C    = 32'hEFC60000;
    localparam word_t UPPER_MASK  = 32'h80000000;
    localparam word_t LOWER_MASK  = 32'h7FFFFFFF;
    localparam word_t DEFAULT_SEED = 32'd5489;

    typedef enum logic [1:0] {
        ACT_DRAW       = 2'd0,
        ACT_SEED_VALUE = 2'd1,
        ACT_WRITE_KEY  = 2'd2,
        ACT_SEED_KEY   = 2'd3
    } action_t;

    // Seeder to top level: busy flag, ring shift enable and the word for the tail.
    typedef struct packed {
        logic  busy;
        logic  shift;
        word_t word;
    } seed_ctrl_t;

    // One step of the twist recurrence without the far term.
    function automatic word_t twist(input word_t upper, input word_t lower);
        word_t y;
        y = (upper & UPPER_MASK) | (lower & LOWER_MASK);
        return (y >> 1) ^ (lower[0] ? MATRIX_A : '0);
    endfunction

    // Output tempering.
    function automatic word_t temper(input word_t x);
        word_t t;
        t = x ^ (x >> 11);
        t = t ^ ((t << 7) & TEMPER_B);
        t = t ^ ((t << 15) & TEMPER_C);
        t = t ^ (t >> 18);
        return t;
    endfunction

endpackage

/* sv/mersenne_twister_generator.sv */
// Top level of the MT19937 generator: ring of state cells, draw path,
// output register and seeding sequencer. Depends on mtg_pkg, mtg_cell, mtg_seeder.
//
// Usage:
// The input channel (in_valid, in_ready) carries one action per transaction:
// draw, seed from value, write key word, or seed from the stored key words.
// Only a draw produces an output transaction (out_valid, out_ready, number).
// Draws stream at one per cycle while the receiver keeps up: each draw twists the
// word at the head of a 624-cell ring with its neighbor and the cell 397 places
// on, tempers it, and shifts the new word into the tail, so the table regenerates
// lazily. The result is in the output register in the cycle after acceptance. A
// value reseed occupies the ring for one initializer pass; a key reseed adds two
// key-mixing passes and an alignment pass, one ring shift per cycle. A key word
// write fills the key store. After reset the block runs the value initializer
// with seed 5489 before in_ready rises. When the receiver stalls, the result holds
// in the output register and a new transaction is taken as soon as it leaves.
module mersenne_twister_generator (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mtg_pkg::action_t  action,
    input  mtg_pkg::word_t    value,
    input  mtg_pkg::key_idx_t key_index,
    input  mtg_pkg::key_cnt_t key_count,
    output logic              out_valid,
    input  logic              out_ready,
    output mtg_pkg::word_t    number
);
    import mtg_pkg::*;

    word_t      ring_word [STATE_WORDS];
    word_t      tail_word;
    word_t      draw_word;
    logic       ring_shift;
    logic       accept;
    logic       draw;
    seed_ctrl_t ctrl;
    logic       out_valid_reg, out_valid_next;
    word_t      number_reg;

    // Handshake.
    assign in_ready = !ctrl.busy && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;
    assign draw     = accept && (action == ACT_DRAW);

    mtg_seeder u_seeder (
        .clk         (clk),
        .rst_n       (rst_n),
        .start_value (accept && (action == ACT_SEED_VALUE)),
        .start_key   (accept && (action == ACT_SEED_KEY)),
        .key_write   (accept && (action == ACT_WRITE_KEY)),
        .value       (value),
        .key_index   (key_index),
        .key_count   (key_count),
        .head        (ring_word[0]),
        .ctrl        (ctrl)
    );

    // Next state word for the current head position.
    assign draw_word  = ring_word[SHIFT_OFFSET] ^ twist(ring_word[0], ring_word[1]);
    assign ring_shift = ctrl.shift || draw;
    assign tail_word  = ctrl.busy ? ctrl.word : draw_word;

    // Ring of state cells; each hands its word toward the head on a shift.
    for (genvar k = 0; k < STATE_WORDS; k++)
    begin : g_ring
        word_t word_in;
        if (k == STATE_WORDS - 1)
        begin : g_tail
            assign word_in = tail_word;
        end
        else
        begin : g_body
            assign word_in = ring_word[k + 1];
        end
        mtg_cell u_cell (
            .clk      (clk),
            .shift    (ring_shift),
            .word_in  (word_in),
            .word_out (ring_word[k])
        );
    end

    // Output register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (draw)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (draw)
        begin
            number_reg <= temper(draw_word);
        end
    end

    assign out_valid = out_valid_reg;
    assign number    = number_reg;

`ifndef SYNTH
    // No transaction is taken while the seeder owns the ring.
    assert property (@(posedge clk) disable iff (!rst_n) ctrl.busy |-> !in_ready)
        else $error("input taken during seeding");

    // An accepted draw always shows a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (action == ACT_DRAW)) |=> out_valid)
        else $error("draw lost");

    // The ring head holds still unless the seeder runs or a draw is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!ctrl.busy && !draw) |=> $stable(ring_word[0]))
        else $error("ring moved while idle");
`endif

endmodule

/* sv/mtg_cell.sv */
// One cell of the state ring: holds one state word and takes its
// neighbor's word whenever the ring shifts. Depends on mtg_pkg.
module mtg_cell (
    input  logic          clk,
    input  logic          shift,
    input  mtg_pkg::word_t word_in,
    output mtg_pkg::word_t word_out
);
    import mtg_pkg::*;

    word_t word_reg;

    // Load the neighbor's word on every ring shift.
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            word_reg <= word_in;
        end
    end

    assign word_out = word_reg;

endmodule

/* sv/mtg_seeder.sv */
// Seeding sequencer: runs the value initializer and the array initializer
// over the ring one word per cycle, and holds the key store. Depends on mtg_pkg.
module mtg_seeder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start_value,
    input  logic               start_key,
    input  logic               key_write,
    input  mtg_pkg::word_t     value,
    input  mtg_pkg::key_idx_t  key_index,
    input  mtg_pkg::key_cnt_t  key_count,
    input  mtg_pkg::word_t     head,
    output mtg_pkg::seed_ctrl_t ctrl
);
    import mtg_pkg::*;

    typedef enum logic [4:0] {
        ST_RUN   = 5'b00001,
        ST_SEED  = 5'b00010,
        ST_KEY1  = 5'b00100,
        ST_KEY2  = 5'b01000,
        ST_ALIGN = 5'b10000
    } seed_state_t;

    localparam pos_t LAST_WORD  = POS_W'(STATE_WORDS - 1);
    localparam pos_t KEY1_WRAP  = POS_W'(STATE_WORDS);
    localparam pos_t KEY1_LAST  = POS_W'(STATE_WORDS + 1);
    localparam pos_t KEY2_WRAP  = POS_W'(STATE_WORDS - 2);
    localparam pos_t ALIGN_LAST = POS_W'(STATE_WORDS - 3);

    seed_state_t state_reg, state_next;
    pos_t        cnt_reg, cnt_next;
    word_t       seed_reg, seed_next;
    word_t       prev_reg, prev_next;
    key_cnt_t    count_reg, count_next;
    key_idx_t    j_reg, j_next;
    logic        key_mode_reg, key_mode_next;
    word_t       key_store_reg [KEY_MAX];

    word_t       mix;
    word_t       mult_const;
    word_t       product;
    word_t       key_word;
    word_t       f1_word;
    word_t       f2_word;
    pos_t        i2;
    word_t       init_word;
    key_cnt_t    count_sat;
    key_cnt_t    j_inc;

    // Shared multiplier on the previous word.
    assign mix = prev_reg ^ (prev_reg >> 30);

    always_comb
    begin
        case (state_reg)
            ST_KEY1: mult_const = MIX1_MULT;
            ST_KEY2: mult_const = MIX2_MULT;
            default: mult_const = INIT_MULT;
        endcase
    end

    assign product  = word_t'(mix * mult_const);
    assign key_word = key_store_reg[j_reg];

    // Word formulas of the two initializers.
    assign init_word = (cnt_reg == '0) ? seed_reg : product + WORD_W'(cnt_reg);
    assign f1_word   = (head ^ product) + key_word + WORD_W'(j_reg);
    assign i2        = (cnt_reg == LAST_WORD) ? POS_W'(1) : cnt_reg + POS_W'(2);
    assign f2_word   = (head ^ product) - WORD_W'(i2);

    // Key count of zero counts as one; above the store size it saturates.
    always_comb
    begin
        if (key_count == '0)
        begin
            count_sat = KEY_CNT_W'(1);
        end
        else if (key_count > KEY_CNT_W'(KEY_MAX))
        begin
            count_sat = KEY_CNT_W'(KEY_MAX);
        end
        else
        begin
            count_sat = key_count;
        end
    end

    assign j_inc = KEY_CNT_W'(j_reg) + KEY_CNT_W'(1);

    // Sequencer.
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        seed_next     = seed_reg;
        prev_next     = prev_reg;
        count_next    = count_reg;
        j_next        = j_reg;
        key_mode_next = key_mode_reg;
        ctrl.busy     = 1'b1;
        ctrl.shift    = 1'b1;
        ctrl.word     = head;
        case (state_reg)
            ST_RUN:
            begin
                ctrl.busy  = 1'b0;
                ctrl.shift = 1'b0;
                if (start_value)
                begin
                    seed_next     = value;
                    key_mode_next = 1'b0;
                    cnt_next      = '0;
                    state_next    = ST_SEED;
                end
                else if (start_key)
                begin
                    seed_next     = ARRAY_SEED;
                    key_mode_next = 1'b1;
                    count_next    = count_sat;
                    j_next        = '0;
                    cnt_next      = '0;
                    state_next    = ST_SEED;
                end
            end
            ST_SEED:
            begin
                ctrl.word = init_word;
                prev_next = init_word;
                if (cnt_reg == LAST_WORD)
                begin
                    cnt_next   = '0;
                    state_next = key_mode_reg ? ST_KEY1 : ST_RUN;
                end
                else
                begin
                    cnt_next = cnt_reg + POS_W'(1);
                end
            end
            ST_KEY1:
            begin
                if (cnt_reg == '0)
                begin
                    prev_next = head;
                end
                else if (cnt_reg != KEY1_WRAP)
                begin
                    ctrl.word = f1_word;
                    prev_next = f1_word;
                    if (j_inc >= count_reg)
                    begin
                        j_next = '0;
                    end
                    else
                    begin
                        j_next = j_reg + KEY_IDX_W'(1);
                    end
                end
                if (cnt_reg == KEY1_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_KEY2;
                end
                else
                begin
                    cnt_next = cnt_reg + POS_W'(1);
                end
            end
            ST_KEY2:
            begin
                if (cnt_reg == KEY2_WRAP)
                begin
                    ctrl.word = UPPER_MASK;
                end
                else
                begin
                    ctrl.word = f2_word;
                    prev_next = f2_word;
                end
                if (cnt_reg == LAST_WORD)
                begin
                    cnt_next   = '0;
                    state_next = ST_ALIGN;
                end
                else
                begin
                    cnt_next = cnt_reg + POS_W'(1);
                end
            end
            ST_ALIGN:
            begin
                if (cnt_reg == ALIGN_LAST)
                begin
                    cnt_next   = '0;
                    state_next = ST_RUN;
                end
                else
                begin
                    cnt_next = cnt_reg + POS_W'(1);
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    // Control registers; reset starts the default seeding pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_SEED;
            cnt_reg      <= '0;
            seed_reg     <= DEFAULT_SEED;
            prev_reg     <= '0;
            count_reg    <= KEY_CNT_W'(1);
            j_reg        <= '0;
            key_mode_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            seed_reg     <= seed_next;
            prev_reg     <= prev_next;
            count_reg    <= count_next;
            j_reg        <= j_next;
            key_mode_reg <= key_mode_next;
        end
    end

    // Key store.
    always_ff @(posedge clk)
    begin
        if (key_write)
        begin
            key_store_reg[key_index] <= value;
        end
    end

endmodule
